// File: design/dff_pkg.sv
package dff_pkg;

  localparam int MAX_HALF_WINDOW = 8;
  localparam int SAMPLE_WIDTH = 16;

  localparam int HIST_DEPTH = 2 * MAX_HALF_WINDOW + 1;
  localparam int HIDX_W = $clog2(HIST_DEPTH);
  localparam int W_W = $clog2(MAX_HALF_WINDOW + 1);
  localparam int J_W = W_W + 1;
  localparam int P_W = W_W + 2;
  localparam int CNT_W = 5;
  localparam int HW_W = 4;
  localparam int COEFF_W = 24;
  localparam int DELTA_W = SAMPLE_WIDTH + $clog2(MAX_HALF_WINDOW * (MAX_HALF_WINDOW + 1) + 1);
  localparam int PROD_W = SAMPLE_WIDTH + J_W;
  localparam int DIFF_W = DELTA_W + 1;
  localparam int SAT_W = (DIFF_W > COEFF_W) ? DIFF_W : COEFF_W;
  localparam int CMP_A = (CNT_W > HW_W) ? CNT_W : HW_W;
  localparam int CMP_B = (W_W + 1 > CMP_A) ? W_W + 1 : CMP_A;
  localparam int CMP_W = CMP_B + 1;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = HW_W;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_WINDOW = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_ORDER = 1'd1;
  localparam logic [HW_W-1:0] HALF_WINDOW_RESET = 4'd2;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;
  localparam logic signed [SAT_W-1:0] COEFF_MAX = SAT_W'(2 ** (COEFF_W - 1) - 1);
  localparam logic signed [SAT_W-1:0] COEFF_MIN = SAT_W'(-(2 ** (COEFF_W - 1)));

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_COMMIT,
    S_EMIT,
    S_EXTRA
  } dff_state_t;

  typedef enum logic {
    SEL_DELTA,
    SEL_EXTRA
  } dff_out_sel_t;

  typedef struct packed {
    logic         accept;
    logic         mac_init;
    logic         mac_step;
    logic         commit;
    logic         d_dec;
    logic         out_load;
    dff_out_sel_t out_sel;
    logic         out_eos;
    logic         seq_end;
  } dff_cmd_t;

  typedef struct packed {
    logic go;
    logic final_item;
    logic mac_last;
    logic d_zero;
    logic out_free;
    logic second_order;
    logic m_ge1;
  } dff_sts_t;

endpackage

// File: design/dff_ctrl.sv
module dff_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  dff_pkg::dff_sts_t sts,
  output dff_pkg::dff_cmd_t cmd
);
  import dff_pkg::*;

  dff_state_t state;
  dff_state_t state_next;
  logic       need_emit;

  assign need_emit = !sts.second_order || sts.m_ge1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid && sts.go) state_next = S_MAC;
      end
      S_MAC: begin
        if (sts.mac_last) state_next = S_COMMIT;
      end
      S_COMMIT: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!need_emit || sts.out_free) begin
          if (sts.final_item && !sts.d_zero) state_next = S_MAC;
          else if (sts.final_item && sts.second_order) state_next = S_EXTRA;
          else state_next = S_IDLE;
        end
      end
      S_EXTRA: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.out_sel = SEL_DELTA;
    in_stall = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          cmd.mac_init = 1'b1;
        end
      end
      S_MAC: begin
        cmd.mac_step = 1'b1;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
      end
      S_EMIT: begin
        if (!need_emit || sts.out_free) begin
          cmd.out_load = need_emit;
          cmd.out_eos = sts.final_item && !sts.second_order && sts.d_zero;
          if (sts.final_item && !sts.d_zero) begin
            cmd.d_dec = 1'b1;
            cmd.mac_init = 1'b1;
          end else if (sts.final_item && !sts.second_order) begin
            cmd.seq_end = 1'b1;
          end
        end
      end
      S_EXTRA: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel = SEL_EXTRA;
          cmd.out_eos = 1'b1;
          cmd.seq_end = 1'b1;
        end
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

// File: design/dff_dpath.sv
module dff_dpath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [dff_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dff_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic signed [dff_pkg::SAMPLE_WIDTH-1:0] sample,
  input  logic                                is_final,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic signed [dff_pkg::COEFF_W-1:0]  coeff,
  output logic                                end_of_sequence,
  input  dff_pkg::dff_cmd_t                   cmd,
  output dff_pkg::dff_sts_t                   sts
);
  import dff_pkg::*;

  logic [HW_W-1:0]                half_window;
  logic                           second_order;
  logic signed [SAMPLE_WIDTH-1:0] history [HIST_DEPTH];
  logic [CNT_W-1:0]               seen_count;
  logic [CNT_W-1:0]               emitted_count;
  logic signed [SAMPLE_WIDTH-1:0] first_sample;
  logic [CNT_W-1:0]               t_reg;
  logic [W_W-1:0]                 w_reg;
  logic [W_W-1:0]                 d_reg;
  logic                           final_reg;
  logic signed [J_W-1:0]          j_reg;
  logic signed [DELTA_W-1:0]      acc;
  logic signed [DELTA_W-1:0]      delta_history [3];
  logic                           m_ge1;
  logic                           m_ge2;

  logic [W_W-1:0]                 w_cfg;
  logic [W_W-1:0]                 w_use;
  logic [P_W-1:0]                 p;
  logic [P_W-2:0]                 p_mag;
  logic signed [SAMPLE_WIDTH-1:0] tap;
  logic signed [PROD_W-1:0]       prod;
  logic signed [DELTA_W-1:0]      sub_b;
  logic signed [DIFF_W-1:0]       diff;
  logic signed [SAT_W-1:0]        diff_ext;
  logic signed [COEFF_W-1:0]      coeff_next;
  logic                           out_free;
  logic                           seen_below_w;

  // window size clamped to the supported maximum
  assign w_cfg = (CMP_W'(half_window) > CMP_W'(MAX_HALF_WINDOW)) ?
                 W_W'(MAX_HALF_WINDOW) : W_W'(half_window);
  assign w_use = cmd.accept ? w_cfg : w_reg;
  assign seen_below_w = CMP_W'(seen_count) < CMP_W'(w_cfg);

  always_ff @(posedge clk) begin
    if (rst) begin
      half_window <= HALF_WINDOW_RESET;
      second_order <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HALF_WINDOW: half_window <= cfg_data[HW_W-1:0];
        REG_SECOND_ORDER: second_order <= cfg_data[0];
        default: half_window <= half_window;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      for (int k = 1; k < HIST_DEPTH; k++) history[k] <= history[k-1];
      history[0] <= sample;
    end
  end

  // tap with edge replication
  assign p = P_W'(d_reg) + P_W'(j_reg);
  assign p_mag = p[P_W-2:0];
  assign tap = p[P_W-1] ? history[0] :
               (CMP_W'(p_mag) > CMP_W'(t_reg)) ? first_sample : history[p_mag[HIDX_W-1:0]];
  assign prod = PROD_W'(j_reg) * PROD_W'(tap);

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_count <= '0;
      emitted_count <= '0;
      first_sample <= '0;
      t_reg <= '0;
      w_reg <= '0;
      d_reg <= '0;
      final_reg <= 1'b0;
      j_reg <= '0;
      m_ge1 <= 1'b0;
      m_ge2 <= 1'b0;
    end else begin
      if (cmd.accept) begin
        if (seen_count == '0) first_sample <= sample;
        t_reg <= seen_count;
        if (seen_count != COUNT_MAX) seen_count <= seen_count + CNT_W'(1);
        w_reg <= w_cfg;
        final_reg <= is_final;
        d_reg <= (is_final && seen_below_w) ? W_W'(seen_count) : w_cfg;
      end
      if (cmd.mac_init) begin
        j_reg <= -$signed(J_W'(w_use));
      end else if (cmd.mac_step) begin
        j_reg <= j_reg + J_W'(1);
      end
      if (cmd.commit) begin
        if (emitted_count != COUNT_MAX) emitted_count <= emitted_count + CNT_W'(1);
        m_ge1 <= emitted_count >= CNT_W'(1);
        m_ge2 <= emitted_count >= CNT_W'(2);
      end
      if (cmd.d_dec) d_reg <= d_reg - W_W'(1);
      if (cmd.seq_end) begin
        seen_count <= '0;
        emitted_count <= '0;
        first_sample <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mac_init) begin
      acc <= '0;
    end else if (cmd.mac_step) begin
      acc <= acc + DELTA_W'(prod);
    end
    if (cmd.commit) begin
      delta_history[2] <= delta_history[1];
      delta_history[1] <= delta_history[0];
      delta_history[0] <= acc;
    end
  end

  // delta, delta-delta, or closing delta-delta at the far edge
  assign sub_b = (cmd.out_sel == SEL_EXTRA) ?
                 ((emitted_count >= CNT_W'(2)) ? delta_history[1] : delta_history[0]) :
                 (second_order ? (m_ge2 ? delta_history[2] : delta_history[1]) : '0);
  assign diff = DIFF_W'(delta_history[0]) - DIFF_W'(sub_b);
  assign diff_ext = SAT_W'(diff);
  assign coeff_next = (diff_ext > COEFF_MAX) ? COEFF_W'(COEFF_MAX) :
                      (diff_ext < COEFF_MIN) ? COEFF_W'(COEFF_MIN) : COEFF_W'(diff_ext);

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      coeff <= coeff_next;
      end_of_sequence <= cmd.out_eos;
    end
  end

  always_comb begin
    sts.go = is_final || !seen_below_w;
    sts.final_item = final_reg;
    sts.mac_last = (j_reg == J_W'(w_reg));
    sts.d_zero = (d_reg == '0);
    sts.out_free = out_free;
    sts.second_order = second_order;
    sts.m_ge1 = m_ge1;
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> out_free)
    else $error("result loaded over an untaken beat");

  a_eos_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load && cmd.out_eos) |=> (seen_count == '0 && emitted_count == '0))
    else $error("sequence counters not cleared after last beat");

  a_tap_range: assert property (@(posedge clk) disable iff (rst)
    cmd.mac_step |-> (j_reg <= $signed({1'b0, w_reg})))
    else $error("tap index past window");

  a_commit_full: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (j_reg == J_W'(w_reg) + J_W'(1)))
    else $error("delta committed before all taps summed");

endmodule

// File: design/delta_feature_filter.sv
// channel | signals                              | accepted when
// --------+--------------------------------------+---------------------------
// in      | in_valid, in_stall, sample, is_final | in_valid && !in_stall
// out     | out_valid, out_stall, coeff,         | out_valid && !out_stall
//         | end_of_sequence                      |
// cfg     | cfg_we, cfg_index, cfg_data          | cfg_we
//
// a sample that yields no delta leaves the block idle; one that yields a delta runs
// a serial multiply-accumulate over the 2W+1 taps, W the clamped half window
// a final sample runs it for each of its n pending positions (up to W+1), followed,
// in delta-delta mode, by the closing delta-delta beat; rst is synchronous and resets all control
// the result register holds a stalled beat while the next sample is taken
// a second result waits in the emit step; in_stall is high while a sample is in work
module delta_feature_filter (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_we,
  input  logic [dff_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [dff_pkg::CFG_DATA_W-1:0]          cfg_data,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [dff_pkg::SAMPLE_WIDTH-1:0] sample,
  input  logic                                    is_final,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [dff_pkg::COEFF_W-1:0]      coeff,
  output logic                                    end_of_sequence
);
  import dff_pkg::*;

  dff_cmd_t cmd;
  dff_sts_t sts;

  dff_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  dff_dpath u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .sample          (sample),
    .is_final        (is_final),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .coeff           (coeff),
    .end_of_sequence (end_of_sequence),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule

// File: bench/delta_feature_filter_tb.sv
`timescale 1ns / 1ps

module delta_feature_filter_tb;
  import dff_pkg::*;

  typedef struct {
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           fin;
  } sample_beat_t;

  typedef struct {
    logic signed [COEFF_W-1:0] coeff;
    logic                      eos;
  } coeff_beat_t;

  logic                           clk;
  logic                           rst;
  logic                           cfg_we;
  logic [CFG_IDX_W-1:0]           cfg_index;
  logic [CFG_DATA_W-1:0]          cfg_data;
  logic                           in_valid;
  logic                           in_stall;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic                           is_final;
  logic                           out_valid;
  logic                           out_stall;
  logic signed [COEFF_W-1:0]      coeff;
  logic                           end_of_sequence;

  delta_feature_filter dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sample(sample),
    .is_final(is_final),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .coeff(coeff),
    .end_of_sequence(end_of_sequence)
  );

  sample_beat_t pending_samples[$];
  coeff_beat_t  expected_coeffs[$];
  coeff_beat_t  step_coeffs[$];

  // predictor state
  logic [HW_W-1:0]                win_reg;
  logic                           dd_mode;
  logic signed [SAMPLE_WIDTH-1:0] sample_hist[HIST_DEPTH];
  logic [CNT_W-1:0]               seen_cnt;
  logic signed [SAMPLE_WIDTH-1:0] seq_first;
  longint                         delta_hist[3];
  logic [CNT_W-1:0]               delta_cnt;

  int  err_cnt = 0;
  int  samples_in = 0;
  int  seqs_in = 0;
  int  coeffs_checked = 0;
  int  queued = 0;
  int  in_gap = 0;
  int  out_gap = 0;
  bit  in_fire = 0;
  bit  out_fire = 0;
  bit  steady = 0;
  bit  hold_out = 0;
  bit  seq_open = 0;

  initial clk = 0;
  always #4 clk = ~clk;

  function automatic int gap_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [SAMPLE_WIDTH-1:0] rand_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'sh7fff;
    if (r == 1) return 16'sh8000;
    if (r == 2) return SAMPLE_WIDTH'($urandom_range(0, 40) - 20);
    return SAMPLE_WIDTH'($urandom());
  endfunction

  // sample p positions behind the newest, edges replicated
  function automatic longint tap_at(int p, int t);
    if (p < 0) return sample_hist[0];
    if (p > t || p >= HIST_DEPTH) return seq_first;
    return sample_hist[p];
  endfunction

  function automatic longint delta_sum(int d, int t, int w);
    longint acc;
    acc = 0;
    for (int j = -w; j <= w; j++) acc += j * tap_at(d + j, t);
    return acc;
  endfunction

  function automatic void add_coeff(longint v);
    coeff_beat_t b;
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    b.coeff = v[COEFF_W-1:0];
    b.eos = 0;
    step_coeffs.push_back(b);
  endfunction

  function automatic void next_delta(int d, int t, int w);
    longint dl;
    int m;
    dl = delta_sum(d, t, w);
    m = delta_cnt;
    delta_hist[2] = delta_hist[1];
    delta_hist[1] = delta_hist[0];
    delta_hist[0] = dl;
    if (delta_cnt < COUNT_MAX) delta_cnt++;
    if (dd_mode) begin
      if (m >= 1) add_coeff(delta_hist[0] - (m >= 2 ? delta_hist[2] : delta_hist[1]));
    end else begin
      add_coeff(dl);
    end
  endfunction

  function automatic void predict_coeffs(logic signed [SAMPLE_WIDTH-1:0] x, logic fin);
    int w;
    int t;
    int dmax;
    int m;
    w = (win_reg > MAX_HALF_WINDOW) ? MAX_HALF_WINDOW : int'(win_reg);
    if (seen_cnt == 0) seq_first = x;
    for (int k = HIST_DEPTH - 1; k > 0; k--) sample_hist[k] = sample_hist[k - 1];
    sample_hist[0] = x;
    t = seen_cnt;
    if (seen_cnt < COUNT_MAX) seen_cnt++;
    if (!fin) begin
      if (t >= w) next_delta(w, t, w);
    end else begin
      dmax = (t < w) ? t : w;
      for (int d = dmax; d >= 0; d--) next_delta(d, t, w);
      if (dd_mode) begin
        m = delta_cnt;
        add_coeff(delta_hist[0] - (m >= 2 ? delta_hist[1] : delta_hist[0]));
      end
      if (step_coeffs.size() > 0) step_coeffs[step_coeffs.size() - 1].eos = 1;
      seen_cnt = 0;
      delta_cnt = 0;
      seq_first = 0;
    end
    foreach (step_coeffs[i]) expected_coeffs.push_back(step_coeffs[i]);
    step_coeffs.delete();
  endfunction

  // accepted beats on both channels
  always @(posedge clk) begin
    coeff_beat_t e;
    in_fire = !rst && in_valid && !in_stall;
    out_fire = !rst && out_valid && !out_stall;
    if (in_fire) begin
      samples_in++;
      if (is_final) seqs_in++;
      predict_coeffs(sample, is_final);
    end
    if (out_fire) begin
      if (expected_coeffs.size() == 0) begin
        $error("unexpected beat: coeff %0d end_of_sequence %0b", coeff, end_of_sequence);
        err_cnt++;
      end else begin
        e = expected_coeffs.pop_front();
        coeffs_checked++;
        if (coeff !== e.coeff) begin
          $error("coeff mismatch: expected %0d, got %0d", e.coeff, coeff);
          err_cnt++;
        end
        if (end_of_sequence !== e.eos) begin
          $error("end_of_sequence mismatch: expected %0b, got %0b", e.eos, end_of_sequence);
          err_cnt++;
        end
      end
    end
  end

  // input driver
  always @(negedge clk) begin
    sample_beat_t it;
    if (!rst) begin
      if (in_valid && in_fire) in_valid = 0;
      if (!in_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_samples.size() > 0) begin
          it = pending_samples.pop_front();
          sample = it.sample;
          is_final = it.fin;
          in_valid = 1;
          in_gap = gap_len();
        end
      end
    end
  end

  // output receiver
  always @(negedge clk) begin
    if (!rst) begin
      if (out_fire) out_gap = gap_len();
      out_stall = hold_out || (out_gap > 0);
      if (out_gap > 0) out_gap--;
    end
  end

  // one long hold-off on the output while samples keep coming
  initial begin
    while (samples_in < 60 || pending_samples.size() < 20) @(posedge clk);
    @(negedge clk);
    hold_out = 1;
    repeat (400) @(negedge clk);
    hold_out = 0;
  end

  initial begin
    #8_000_000;
    $display("Some tests failed");
    $finish;
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(negedge clk);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = CFG_DATA_W'(val);
    @(posedge clk);
    if (idx == REG_HALF_WINDOW) win_reg = HW_W'(val);
    else dd_mode = val[0];
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic wait_idle();
    while (pending_samples.size() > 0 || in_valid || expected_coeffs.size() > 0)
      @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  task automatic push_sample(input logic signed [SAMPLE_WIDTH-1:0] x, input logic fin);
    sample_beat_t b;
    b.sample = x;
    b.fin = fin;
    pending_samples.push_back(b);
    queued++;
    seq_open = !fin;
  endtask

  task automatic push_rand_seq(input int len, input bit close);
    for (int i = 0; i < len; i++) push_sample(rand_sample(), close && (i == len - 1));
  endtask

  initial begin
    int phase;
    int budget;
    int len;
    int r;
    bit leave_open;
    rst = 1;
    cfg_we = 0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 0;
    sample = '0;
    is_final = 0;
    out_stall = 0;
    win_reg = HALF_WINDOW_RESET;
    dd_mode = 0;
    seen_cnt = 0;
    delta_cnt = 0;
    seq_first = 0;
    foreach (sample_hist[i]) sample_hist[i] = 0;
    foreach (delta_hist[i]) delta_hist[i] = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // reset settings: extremes, single sample, short sequence
    push_sample(16'sh7fff, 0);
    push_sample(16'sh8000, 0);
    push_sample(16'sh7fff, 0);
    push_sample(16'sh8000, 0);
    push_sample(16'sh0000, 0);
    push_sample(16'sh0001, 0);
    push_sample(16'shffff, 1);
    push_sample(16'sh8000, 1);
    push_sample(16'sh0005, 0);
    push_sample(16'sh0007, 1);
    wait_idle();

    // window zero
    write_reg(REG_HALF_WINDOW, 0);
    push_sample(16'sd100, 0);
    push_sample(-16'sd200, 0);
    push_sample(16'sd300, 1);
    wait_idle();

    // widest window in delta-delta mode, then a lone sample
    write_reg(REG_HALF_WINDOW, 8);
    write_reg(REG_SECOND_ORDER, 1);
    push_sample(16'sh7fff, 0);
    push_sample(16'sh8000, 0);
    push_sample(16'sh7fff, 0);
    push_sample(16'sh7fff, 0);
    push_sample(16'sh8000, 0);
    push_sample(16'sh0000, 1);
    push_sample(16'sd1234, 1);
    wait_idle();

    // settings changed in the middle of a sequence, oversized window
    write_reg(REG_HALF_WINDOW, 3);
    push_sample(16'sh5555, 0);
    push_sample(16'shaaaa, 0);
    push_sample(16'sh7fff, 0);
    wait_idle();
    write_reg(REG_HALF_WINDOW, 15);
    write_reg(REG_SECOND_ORDER, 0);
    push_sample(16'sh8000, 0);
    push_sample(16'sh1234, 1);
    wait_idle();

    phase = 0;
    while (queued < 360) begin
      case (phase)
        0: begin
          write_reg(REG_HALF_WINDOW, 8);
          write_reg(REG_SECOND_ORDER, 1);
        end
        1: begin
          write_reg(REG_HALF_WINDOW, 1);
          write_reg(REG_SECOND_ORDER, 0);
        end
        default: begin
          r = $urandom_range(0, 19);
          if (r == 0) write_reg(REG_HALF_WINDOW, 0);
          else if (r == 1) write_reg(REG_HALF_WINDOW, $urandom_range(9, 15));
          else write_reg(REG_HALF_WINDOW, $urandom_range(1, 8));
          write_reg(REG_SECOND_ORDER, $urandom_range(0, 1));
        end
      endcase
      steady = ($urandom_range(0, 3) == 0);
      leave_open = (phase > 2) && ($urandom_range(0, 3) == 0);
      budget = $urandom_range(30, 50);
      while (budget > 0) begin
        r = $urandom_range(0, 99);
        if (phase == 0 && budget > 40) len = 40;
        else if (r < 80) len = $urandom_range(1, 12);
        else if (r < 95) len = $urandom_range(13, 24);
        else len = $urandom_range(25, 40);
        budget -= len;
        push_rand_seq(len, !(leave_open && budget <= 0));
      end
      wait_idle();
      phase++;
    end
    if (seq_open) push_rand_seq(1, 1);
    steady = 0;

    while (pending_samples.size() > 0 || in_valid) @(posedge clk);
    while (expected_coeffs.size() > 0) @(posedge clk);
    repeat (250) @(posedge clk);
    if (expected_coeffs.size() > 0) err_cnt++;

    $display("checked %0d coefficients from %0d samples in %0d sequences",
             coeffs_checked, samples_in, seqs_in);
    $display("half windows 0 to 15, delta and delta-delta modes, long output hold-off");
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
